>>> src/slc_pkg.sv
// Package for the source line classifier: widths, types, register codes and helpers.
// Depends on nothing; the core, front, queue and back import it.
package slc_pkg;

  localparam int SymbolBytes = 4;
  localparam int RegBits     = 35;
  localparam int CountBits   = 32;
  localparam int LenBits     = 8;
  localparam int LenSat      = 255;
  localparam int NumCfg      = 6;
  localparam int CfgIdxBits  = 3;
  localparam int WinBits     = 8 * SymbolBytes;

  typedef logic [RegBits-1:0]   sym_reg_t;
  typedef logic [WinBits-1:0]   win_t;
  typedef logic [LenBits-1:0]   len_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [1:0]           kind_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LINE_A  = 3'd0,
    CFG_LINE_B  = 3'd1,
    CFG_OPEN_A  = 3'd2,
    CFG_CLOSE_A = 3'd3,
    CFG_OPEN_B  = 3'd4,
    CFG_CLOSE_B = 3'd5
  } cfg_idx_t;

  localparam kind_t KIND_EMPTY   = 2'd0;
  localparam kind_t KIND_COMMENT = 2'd1;
  localparam kind_t KIND_CODE    = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  localparam sym_reg_t LINE_A_RST  = 35'd8589946671;
  localparam sym_reg_t OPEN_A_RST  = 35'd8589945391;
  localparam sym_reg_t CLOSE_A_RST = 35'd8589946666;

  // Summary of one finished line, passed from front to back through the queue.
  typedef struct packed {
    logic  fin;
    logic  pending;
    logic  nonempty;
    logic  any_pair;
    logic  line_hit;
    logic  closed_hit;
    logic  head_open_a;
    logic  head_open_b;
    logic  tail_close_a;
    logic  tail_close_b;
  } line_sum_t;

  typedef struct packed {
    kind_t  kind;
    logic   fin;
    count_t total;
    count_t empty;
    count_t comment;
    count_t code;
  } result_t;

  // Effective symbol length, clipped to the window.
  function automatic logic [2:0] sym_len(input sym_reg_t r);
    logic [2:0] n;
    n = r[34:32];
    return (n > 3'(SymbolBytes)) ? 3'(SymbolBytes) : n;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // Symbol ends at newest window byte (lowest); n bytes valid.
  function automatic logic match_tail(input win_t w, input len_t n, input sym_reg_t r);
    logic [2:0] l;
    logic ok;
    l = sym_len(r);
    ok = (n >= len_t'(l));
    for (int i = 0; i < SymbolBytes; i++) begin
      if (i < int'(l)) begin
        if (w[8*(int'(l)-1-i) +: 8] != r[8*i +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic match_head(input win_t h, input len_t n, input sym_reg_t r);
    logic [2:0] l;
    logic ok;
    l = sym_len(r);
    ok = (n >= len_t'(l));
    for (int i = 0; i < SymbolBytes; i++) begin
      if (i < int'(l)) begin
        if (h[8*i +: 8] != r[8*i +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

>>> src/slc_if.sv
// Valid/ready channel interfaces for the input bytes and the line results.
// Depends on no other file.
interface slc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       stream_end;
  modport source (output valid, char_byte, stream_end, input ready);
  modport sink (input valid, char_byte, stream_end, output ready);
endinterface

interface slc_out_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              line_kind;
  logic                    finished;
  logic [31:0]             total_lines;
  logic [31:0]             empty_lines;
  logic [31:0]             comment_lines;
  logic [31:0]             code_lines;
  modport source (output valid, line_kind, finished, total_lines, empty_lines,
                  comment_lines, code_lines, input ready);
  modport sink (input valid, line_kind, finished, total_lines, empty_lines,
                comment_lines, code_lines, output ready);
endinterface

>>> src/source_line_classifier_core.sv
// Top level of the source line classifier: config registers, front, queue, back.
// Depends on slc_pkg, slc_if, slc_front, slc_queue and slc_back.
//
//  channel | direction | handshake    | payload
//  in_     | sink      | valid/ready  | char_byte[8], stream_end
//  out_    | source    | valid/ready  | line_kind[2], finished, 4 x 32-bit counters
//  cfg_    | write     | cfg_we       | cfg_index[3], cfg_data[35]
//
// One byte per cycle sustained while results drain. A line summary is written to the queue
// at the edge that takes its newline and then passes through the output register
// before it is offered on out_. Reset is synchronous on rst_n and restores
// default symbols and clears all counters. Every input item, newline or not, waits
// while the two-entry line queue is full, i.e. when the output holds back results.
module source_line_classifier_core (
  input  logic                            clk,
  input  logic                            rst_n,
  slc_in_if.sink                          in_ch,
  slc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [slc_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [slc_pkg::RegBits-1:0]     cfg_data
);
  import slc_pkg::*;

  sym_reg_t  line_a_r, line_b_r, open_a_r, close_a_r, open_b_r, close_b_r;
  logic      f_valid, f_ready, q_valid, q_ready;
  line_sum_t f_sum, q_sum;
  result_t   res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_a_r  <= LINE_A_RST;
      line_b_r  <= '0;
      open_a_r  <= OPEN_A_RST;
      close_a_r <= CLOSE_A_RST;
      open_b_r  <= '0;
      close_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_A:  line_a_r  <= cfg_data;
        CFG_LINE_B:  line_b_r  <= cfg_data;
        CFG_OPEN_A:  open_a_r  <= cfg_data;
        CFG_CLOSE_A: close_a_r <= cfg_data;
        CFG_OPEN_B:  open_b_r  <= cfg_data;
        CFG_CLOSE_B: close_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  slc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .char_byte  (in_ch.char_byte),
    .stream_end (in_ch.stream_end),
    .byte_ready (in_ch.ready),
    .line_a     (line_a_r),
    .line_b     (line_b_r),
    .open_a     (open_a_r),
    .close_a    (close_a_r),
    .open_b     (open_b_r),
    .close_b    (close_b_r),
    .sum_valid  (f_valid),
    .sum        (f_sum),
    .sum_ready  (f_ready)
  );

  slc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_data  (f_sum),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_data  (q_sum),
    .rd_ready (q_ready)
  );

  slc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (q_valid),
    .sum       (q_sum),
    .sum_ready (q_ready),
    .open_a    (open_a_r),
    .open_b    (open_b_r),
    .res_valid (out_ch.valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.line_kind     = res.kind;
  assign out_ch.finished      = res.fin;
  assign out_ch.total_lines   = res.total;
  assign out_ch.empty_lines   = res.empty;
  assign out_ch.comment_lines = res.comment;
  assign out_ch.code_lines    = res.code;

endmodule

>>> src/slc_front.sv
// Front: scans bytes, tracks trimmed-line windows and symbol matches per line.
// Depends on slc_pkg; emits one line summary per newline or stream end.
module slc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          char_byte,
  input  logic                stream_end,
  output logic                byte_ready,
  input  slc_pkg::sym_reg_t   line_a,
  input  slc_pkg::sym_reg_t   line_b,
  input  slc_pkg::sym_reg_t   open_a,
  input  slc_pkg::sym_reg_t   close_a,
  input  slc_pkg::sym_reg_t   open_b,
  input  slc_pkg::sym_reg_t   close_b,
  output logic                sum_valid,
  output slc_pkg::line_sum_t  sum,
  input  logic                sum_ready
);
  import slc_pkg::*;

  logic       pending_r, pending_nxt;
  win_t       head_r, head_nxt;
  win_t       raw_r, raw_nxt;
  win_t       tail_r, tail_nxt;
  len_t       cur_r, cur_nxt;
  len_t       trim_r, trim_nxt;
  logic [1:0] seen_r, seen_nxt, tent_r, tent_nxt;
  logic [1:0] closed_r, closed_nxt, ctent_r, ctent_nxt;
  len_t       since_r [2];
  len_t       since_nxt [2];

  sym_reg_t   osym [2];
  sym_reg_t   csym [2];
  logic       take, line_end, ws;

  assign osym[0] = open_a;
  assign osym[1] = open_b;
  assign csym[0] = close_a;
  assign csym[1] = close_b;

  assign byte_ready = sum_ready;
  assign take       = byte_valid && byte_ready;
  assign line_end   = stream_end || (char_byte == 8'd10);
  assign ws         = is_blank(char_byte);

  // Per-byte window and match update
  always_comb begin
    win_t rw;
    len_t cl;
    pending_nxt = pending_r;
    head_nxt    = head_r;
    raw_nxt     = raw_r;
    tail_nxt    = tail_r;
    cur_nxt     = cur_r;
    trim_nxt    = trim_r;
    seen_nxt    = seen_r;
    tent_nxt    = tent_r;
    closed_nxt  = closed_r;
    ctent_nxt   = ctent_r;
    since_nxt   = since_r;
    rw          = {raw_r[WinBits-9:0], char_byte};
    cl          = (cur_r < len_t'(LenSat)) ? cur_r + len_t'(1) : cur_r;
    if (take) begin
      if (line_end) begin
        pending_nxt = 1'b0;
        head_nxt    = '0;
        raw_nxt     = '0;
        tail_nxt    = '0;
        cur_nxt     = '0;
        trim_nxt    = '0;
        seen_nxt    = '0;
        tent_nxt    = '0;
        closed_nxt  = '0;
        ctent_nxt   = '0;
        since_nxt[0] = '0;
        since_nxt[1] = '0;
      end else begin
        pending_nxt = 1'b1;
        if (!(cur_r == '0 && ws)) begin
          if (cur_r < len_t'(SymbolBytes)) head_nxt[8*cur_r[1:0] +: 8] = char_byte;
          cur_nxt = cl;
          raw_nxt = rw;
          for (int p = 0; p < 2; p++) begin
            if (sym_len(osym[p]) != 3'd0) begin
              if (seen_r[p] || tent_r[p]) begin
                if (since_r[p] < len_t'(LenSat)) since_nxt[p] = since_r[p] + len_t'(1);
                if (!closed_r[p] && sym_len(csym[p]) != 3'd0 &&
                    since_nxt[p] >= len_t'(sym_len(csym[p])) && match_tail(rw, cl, csym[p])) begin
                  if (ws) ctent_nxt[p] = 1'b1;
                  else closed_nxt[p] = 1'b1;
                end
              end else if (match_tail(rw, cl, osym[p])) begin
                since_nxt[p] = '0;
                if (ws) tent_nxt[p] = 1'b1;
                else seen_nxt[p] = 1'b1;
                if (sym_len(csym[p]) == 3'd0) begin
                  if (ws) ctent_nxt[p] = 1'b1;
                  else closed_nxt[p] = 1'b1;
                end
              end
            end
          end
          if (!ws) begin
            seen_nxt   = seen_nxt | tent_nxt;
            closed_nxt = closed_nxt | ctent_nxt;
            tent_nxt   = '0;
            ctent_nxt  = '0;
            trim_nxt   = cl;
            tail_nxt   = rw;
          end
        end
      end
    end
  end

  // Line summary for the back end
  always_comb begin
    sum.fin          = stream_end;
    sum.pending      = pending_r;
    sum.nonempty     = (trim_r != '0);
    sum.any_pair     = (sym_len(open_a) != 3'd0) || (sym_len(open_b) != 3'd0);
    sum.line_hit     = (sym_len(line_a) != 3'd0 && match_head(head_r, trim_r, line_a)) ||
                       (sym_len(line_b) != 3'd0 && match_head(head_r, trim_r, line_b));
    sum.closed_hit   = (sym_len(open_a) != 3'd0 && closed_r[0]) ||
                       (sym_len(open_b) != 3'd0 && closed_r[1]);
    sum.head_open_a  = sym_len(open_a) != 3'd0 && match_head(head_r, trim_r, open_a);
    sum.head_open_b  = sym_len(open_b) != 3'd0 && match_head(head_r, trim_r, open_b);
    sum.tail_close_a = match_tail(tail_r, trim_r, close_a);
    sum.tail_close_b = match_tail(tail_r, trim_r, close_b);
  end
  assign sum_valid = byte_valid && line_end;

  // Hold line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      head_r     <= '0;
      raw_r      <= '0;
      tail_r     <= '0;
      cur_r      <= '0;
      trim_r     <= '0;
      seen_r     <= '0;
      tent_r     <= '0;
      closed_r   <= '0;
      ctent_r    <= '0;
      since_r[0] <= '0;
      since_r[1] <= '0;
    end else begin
      pending_r  <= pending_nxt;
      head_r     <= head_nxt;
      raw_r      <= raw_nxt;
      tail_r     <= tail_nxt;
      cur_r      <= cur_nxt;
      trim_r     <= trim_nxt;
      seen_r     <= seen_nxt;
      tent_r     <= tent_nxt;
      closed_r   <= closed_nxt;
      ctent_r    <= ctent_nxt;
      since_r[0] <= since_nxt[0];
      since_r[1] <= since_nxt[1];
    end
  end

endmodule

>>> src/slc_queue.sv
// Two-entry queue of line summaries between front and back.
// Depends on slc_pkg for the summary type.
module slc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  input  slc_pkg::line_sum_t wr_data,
  output logic               wr_ready,
  output logic               rd_valid,
  output slc_pkg::line_sum_t rd_data,
  input  logic               rd_ready
);
  import slc_pkg::*;

  line_sum_t  mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  // Advance pointers and count
  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> src/slc_back.sv
// Back: classifies each line summary, keeps block state and counters, registers result.
// Depends on slc_pkg.
module slc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sum_valid,
  input  slc_pkg::line_sum_t sum,
  output logic               sum_ready,
  input  slc_pkg::sym_reg_t  open_a,
  input  slc_pkg::sym_reg_t  open_b,
  output logic               res_valid,
  output slc_pkg::result_t   res,
  input  logic               res_ready
);
  import slc_pkg::*;

  logic    in_block_r, in_block_nxt;
  logic    pair_r, pair_nxt;
  count_t  cnt_r [4];
  count_t  cnt_nxt [4];
  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;
  kind_t   kind;
  logic    take, close_hit;

  assign sum_ready = !valid_r || res_ready;
  assign take      = sum_valid && sum_ready;

  // Shared start: close by the first pair with an equal start register
  assign close_hit = (pair_r && open_a != open_b) ? sum.tail_close_b : sum.tail_close_a;

  // Classify the line
  always_comb begin
    kind         = KIND_CODE;
    in_block_nxt = in_block_r;
    pair_nxt     = pair_r;
    if (sum.fin && !sum.pending) begin
      kind = KIND_NONE;
    end else if (!sum.nonempty) begin
      kind = KIND_EMPTY;
    end else if (!sum.any_pair) begin
      kind = sum.line_hit ? KIND_COMMENT : KIND_CODE;
    end else if (in_block_r) begin
      kind = KIND_COMMENT;
      if (close_hit) in_block_nxt = 1'b0;
    end else if (sum.closed_hit) begin
      kind = KIND_COMMENT;
    end else if (sum.head_open_a) begin
      kind = KIND_COMMENT;
      in_block_nxt = 1'b1;
      pair_nxt = 1'b0;
    end else if (sum.head_open_b) begin
      kind = KIND_COMMENT;
      in_block_nxt = 1'b1;
      pair_nxt = 1'b1;
    end else begin
      kind = sum.line_hit ? KIND_COMMENT : KIND_CODE;
    end
  end

  // Bump saturating counters
  always_comb begin
    cnt_nxt = cnt_r;
    if (kind != KIND_NONE) begin
      if (cnt_r[0] != '1) cnt_nxt[0] = cnt_r[0] + count_t'(1);
      case (kind)
        KIND_EMPTY:   if (cnt_r[1] != '1) cnt_nxt[1] = cnt_r[1] + count_t'(1);
        KIND_COMMENT: if (cnt_r[2] != '1) cnt_nxt[2] = cnt_r[2] + count_t'(1);
        default:      if (cnt_r[3] != '1) cnt_nxt[3] = cnt_r[3] + count_t'(1);
      endcase
    end
  end

  // Output register
  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_ready) valid_nxt = 1'b0;
    if (take) begin
      valid_nxt       = 1'b1;
      res_nxt.kind    = kind;
      res_nxt.fin     = sum.fin;
      res_nxt.total   = cnt_nxt[0];
      res_nxt.empty   = cnt_nxt[1];
      res_nxt.comment = cnt_nxt[2];
      res_nxt.code    = cnt_nxt[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r <= 1'b0;
      pair_r     <= 1'b0;
      valid_r    <= 1'b0;
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        in_block_r <= in_block_nxt;
        pair_r     <= pair_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

>>> src/slc_checker.sv
// Port-level checker for the source line classifier, bound to the top level.
// Depends on the top level's port names only.
module slc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  line_kind,
  input logic        finished,
  input logic [31:0] total_lines,
  input logic [31:0] empty_lines
);
  // A result with no line only comes from a stream end
  a_none_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_kind == 2'd3 |-> finished) else $error("no-line result not finished");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(total_lines))
    else $error("stalled result changed");

  // Empty lines never exceed total lines
  a_empty_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> empty_lines <= total_lines) else $error("empty count above total");

  // Total count does not run backward between consecutive results
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |-> total_lines >= $past(total_lines))
    else $error("total count went down");
endmodule

bind source_line_classifier_core slc_checker u_slc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .line_kind   (out_ch.line_kind),
  .finished    (out_ch.finished),
  .total_lines (out_ch.total_lines),
  .empty_lines (out_ch.empty_lines)
);
